>>> hw/rtl/tgc_pkg.sv
`timescale 1ns / 1ps
package tgc_pkg;

   localparam int COORD_BITS    = 10;
   localparam int POS_BITS      = 10;
   localparam int PCT_BITS      = 7;
   localparam int DIV_BITS      = COORD_BITS + PCT_BITS;
   localparam int CNT_BITS      = $clog2(DIV_BITS + 1);
   localparam int CSR_IDX_BITS  = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DIV_BITS-1:0]   wide_type;
   typedef logic [POS_BITS-1:0]   pos_type;

   localparam coord_type MIN_X_RST = coord_type'(20);
   localparam coord_type MAX_X_RST = coord_type'(526);
   localparam coord_type MIN_Y_RST = coord_type'(5);
   localparam coord_type MAX_Y_RST = coord_type'(791);

   localparam wide_type PCT_SCALE     = wide_type'(100);
   localparam wide_type PCT_ZERO_SPAN = wide_type'(50);

   localparam logic [7:0] TAP_DIV_RST   = 8'd20;
   localparam logic [7:0] SWIPE_DIV_RST = 8'd6;
   localparam logic [6:0] HOME_PCT_RST  = 7'd85;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_DIV   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWIPE_DIV = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOME_PCT  = 2'd2;

   localparam logic OP_DOWN = 1'b0;
   localparam logic OP_UP   = 1'b1;

   typedef enum logic [2:0] {
      GEST_TAP   = 3'd0,
      GEST_AMBIG = 3'd1,
      GEST_HOME  = 3'd2,
      GEST_RIGHT = 3'd3,
      GEST_LEFT  = 3'd4,
      GEST_DOWN  = 3'd5,
      GEST_UP    = 3'd6
   } gesture_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TAP  = 5'b00010,
      ST_SWP  = 5'b00100,
      ST_PCT  = 5'b01000,
      ST_EMIT = 5'b10000
   } back_state_type;

   typedef struct packed {
      logic [7:0] tap_divisor;
      logic [7:0] swipe_divisor;
      logic [6:0] home_zone_pct;
   } cfg_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type last_x;
      coord_type last_y;
      coord_type min_y;
      coord_type span_x;
      coord_type span_y;
   } job_type;

endpackage

>>> hw/rtl/tgc_front.sv
`timescale 1ns / 1ps
module tgc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   input  logic [9:0]       req_pos_x,
   input  logic [9:0]       req_pos_y,
   input  logic             q_full,
   output logic             push,
   output tgc_pkg::job_type push_data
);
   import tgc_pkg::*;

   logic      active_ff, active_in;
   coord_type start_x_ff, start_x_in, start_y_ff, start_y_in;
   coord_type last_x_ff, last_x_in, last_y_ff, last_y_in;
   coord_type min_x_ff, min_x_in, max_x_ff, max_x_in;
   coord_type min_y_ff, min_y_in, max_y_ff, max_y_in;
   coord_type x, y;
   logic      accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign x         = coord_type'(req_pos_x);
   assign y         = coord_type'(req_pos_y);
   assign push      = accept && (req_op == OP_UP) && active_ff;

   always_comb begin
      push_data.start_x = start_x_ff;
      push_data.start_y = start_y_ff;
      push_data.last_x  = last_x_ff;
      push_data.last_y  = last_y_ff;
      push_data.min_y   = min_y_ff;
      push_data.span_x  = (max_x_ff >= min_x_ff) ? max_x_ff - min_x_ff : '0;
      push_data.span_y  = (max_y_ff >= min_y_ff) ? max_y_ff - min_y_ff : '0;
   end

   always_comb begin
      active_in  = active_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      min_x_in   = min_x_ff;
      max_x_in   = max_x_ff;
      min_y_in   = min_y_ff;
      max_y_in   = max_y_ff;
      if (accept && req_op == OP_DOWN) begin
         if (!active_ff) begin
            start_x_in = x;
            start_y_in = y;
         end
         last_x_in = x;
         last_y_in = y;
         active_in = 1'b1;
         if (x < min_x_ff) min_x_in = x;
         if (x > max_x_ff) max_x_in = x;
         if (y < min_y_ff) min_y_in = y;
         if (y > max_y_ff) max_y_in = y;
      end else if (push) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         min_x_ff   <= MIN_X_RST;
         max_x_ff   <= MAX_X_RST;
         min_y_ff   <= MIN_Y_RST;
         max_y_ff   <= MAX_Y_RST;
      end else begin
         active_ff  <= active_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         min_x_ff   <= min_x_in;
         max_x_ff   <= max_x_in;
         min_y_ff   <= min_y_in;
         max_y_ff   <= max_y_in;
      end
   end

endmodule

>>> hw/rtl/tgc_queue.sv
`timescale 1ns / 1ps
module tgc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tgc_pkg::job_type push_data,
   input  logic             pop,
   output tgc_pkg::job_type pop_data,
   output logic             full,
   output logic             empty
);
   import tgc_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/tgc_back.sv
`timescale 1ns / 1ps
module tgc_back (
   input  logic             clock,
   input  logic             reset,
   input  tgc_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  tgc_pkg::job_type pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_gesture,
   output logic [9:0]       rsp_end_x,
   output logic [9:0]       rsp_end_y
);
   import tgc_pkg::*;

   back_state_type        state_ff, state_in;
   job_type               job_ff, job_in;
   wide_type              rem_ff, rem_in, quo_ff, quo_in;
   coord_type             divisor_ff, divisor_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   wide_type              tap_thr_ff, tap_thr_in, swp_thr_ff, swp_thr_in, pct_ff, pct_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gesture_type           gesture_ff, gesture_in;
   pos_type               end_x_ff, end_x_in, end_y_ff, end_y_in;

   logic [DIV_BITS:0]     shifted;
   logic [DIV_BITS:0]     diff;
   logic                  fits;
   coord_type             tdiv, sdiv, range_new, range_job;
   coord_type             adx, ady;
   wide_type              height;
   logic                  emit;
   gesture_type           gesture;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = gesture_ff;
   assign rsp_end_x   = end_x_ff;
   assign rsp_end_y   = end_y_ff;

   assign tdiv      = (cfg.tap_divisor == '0) ? coord_type'(1) : coord_type'(cfg.tap_divisor);
   assign sdiv      = (cfg.swipe_divisor == '0) ? coord_type'(1)
                                                : coord_type'(cfg.swipe_divisor);
   assign range_new = (pop_data.span_x > pop_data.span_y) ? pop_data.span_x : pop_data.span_y;
   assign range_job = (job_ff.span_x > job_ff.span_y) ? job_ff.span_x : job_ff.span_y;
   assign height    = wide_type'(job_ff.start_y - job_ff.min_y) * PCT_SCALE;

   assign shifted = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff    = shifted - (DIV_BITS + 1)'(divisor_ff);
   assign fits    = shifted >= (DIV_BITS + 1)'(divisor_ff);

   assign adx = (job_ff.last_x >= job_ff.start_x) ? job_ff.last_x - job_ff.start_x
                                                  : job_ff.start_x - job_ff.last_x;
   assign ady = (job_ff.last_y >= job_ff.start_y) ? job_ff.last_y - job_ff.start_y
                                                  : job_ff.start_y - job_ff.last_y;

   always_comb begin
      if (wide_type'(adx) < tap_thr_ff && wide_type'(ady) < tap_thr_ff) begin
         gesture = GEST_TAP;
      end else if (wide_type'(adx) < swp_thr_ff && wide_type'(ady) < swp_thr_ff) begin
         gesture = GEST_AMBIG;
      end else if (pct_ff > wide_type'(cfg.home_zone_pct) && job_ff.last_y < job_ff.start_y
                   && wide_type'(ady) > swp_thr_ff) begin
         gesture = GEST_HOME;
      end else if (adx > ady) begin
         gesture = (job_ff.last_x > job_ff.start_x) ? GEST_RIGHT : GEST_LEFT;
      end else begin
         gesture = (job_ff.last_y > job_ff.start_y) ? GEST_DOWN : GEST_UP;
      end
   end

   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign pop  = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      cnt_in       = cnt_ff;
      tap_thr_in   = tap_thr_ff;
      swp_thr_in   = swp_thr_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      gesture_in   = gesture_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;

      if (state_ff != ST_IDLE && state_ff != ST_EMIT && cnt_ff != '0) begin
         rem_in = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               job_in     = pop_data;
               rem_in     = '0;
               quo_in     = wide_type'(range_new);
               divisor_in = tdiv;
               cnt_in     = CNT_BITS'(DIV_BITS);
               state_in   = ST_TAP;
            end
         end
         ST_TAP: begin
            if (cnt_ff == '0) begin
               tap_thr_in = quo_ff;
               rem_in     = '0;
               quo_in     = wide_type'(range_job);
               divisor_in = sdiv;
               cnt_in     = CNT_BITS'(DIV_BITS);
               state_in   = ST_SWP;
            end
         end
         ST_SWP: begin
            if (cnt_ff == '0) begin
               swp_thr_in = quo_ff;
               rem_in     = '0;
               quo_in     = height;
               divisor_in = job_ff.span_y;
               cnt_in     = CNT_BITS'(DIV_BITS);
               state_in   = ST_PCT;
            end
         end
         ST_PCT: begin
            if (cnt_ff == '0) begin
               if (job_ff.span_y == '0) begin
                  pct_in = PCT_ZERO_SPAN;
               end else if (job_ff.start_y < job_ff.min_y) begin
                  pct_in = '0;
               end else begin
                  pct_in = quo_ff;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               gesture_in   = gesture;
               end_x_in     = pos_type'(job_ff.last_x);
               end_y_in     = pos_type'(job_ff.last_y);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      tap_thr_ff <= tap_thr_in;
      swp_thr_ff <= swp_thr_in;
      pct_ff     <= pct_in;
      gesture_ff <= gesture_in;
      end_x_ff   <= end_x_in;
      end_y_ff   <= end_y_in;
   end

endmodule

>>> hw/rtl/touch_gesture_classifier.sv
`timescale 1ns / 1ps
// Touch gesture classifier.
// Request channel (req_valid/req_ready, req_op, req_pos_x, req_pos_y) takes touch
// events: op 0 is a down or move, op 1 is an up. Down/move items update the
// stroke start, last point and calibration bounds in the cycle they are taken.
// An up item that ends an active stroke produces one response item on the
// rsp_ channel (rsp_gesture, rsp_end_x, rsp_end_y); other up items produce none.
// An item is taken whenever the two-entry stroke queue has room.
// A finished stroke is classified by one shared restoring divider, one quotient
// bit per cycle, run three times (tap threshold, swipe threshold, start height
// percentage); strokes are classified one at a time, the next one leaving the
// queue only once the classifier is back in its idle state.
// Configuration: csr_we with csr_index 0 tap divisor, 1 swipe divisor,
// 2 home zone percentage; write only while no stroke is in flight.
// Reset (synchronous, active high) clears the stroke, queue and response,
// restores the default bounds and register values.
// When the receiver holds rsp_ready low, the response is held; the divider
// stalls once it has a new result, then the queue fills and req_ready drops.
module touch_gesture_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [9:0] req_pos_x,
   input  logic [9:0] req_pos_y,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_gesture,
   output logic [9:0] rsp_end_x,
   output logic [9:0] rsp_end_y,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   import tgc_pkg::*;

   cfg_type cfg_ff;
   job_type push_data, pop_data;
   logic    push, pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_divisor   <= TAP_DIV_RST;
         cfg_ff.swipe_divisor <= SWIPE_DIV_RST;
         cfg_ff.home_zone_pct <= HOME_PCT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_DIV:   cfg_ff.tap_divisor   <= csr_data;
            CSR_SWIPE_DIV: cfg_ff.swipe_divisor <= csr_data;
            CSR_HOME_PCT:  cfg_ff.home_zone_pct <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   tgc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   tgc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   tgc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_gesture (rsp_gesture),
      .rsp_end_x   (rsp_end_x),
      .rsp_end_y   (rsp_end_y)
   );

endmodule

>>> tb/tb_touch_gesture_classifier.sv
`timescale 1ns / 1ps
module tb_touch_gesture_classifier;
   import tgc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = 120;
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int PHASE_ITEMS     = 100;
   localparam int NUM_PHASES      = 7;
   localparam int NUM_DIRECTED    = 27;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      gesture_type gesture;
      pos_type     end_x;
      pos_type     end_y;
   } stroke_result_type;

   typedef struct {
      logic              op;
      coord_type         x;
      coord_type         y;
      bit                typed;
      bit                yields;
      stroke_result_type want;
   } directed_row_type;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_op    = 1'b0;
   logic [9:0] req_pos_x = '0;
   logic [9:0] req_pos_y = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_gesture;
   logic [9:0] rsp_end_x;
   logic [9:0] rsp_end_y;
   logic       csr_we    = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data  = '0;

   // shadow of the block's stroke state and registers
   bit         stroke_on   = 1'b0;
   coord_type  org_x       = '0;
   coord_type  org_y       = '0;
   coord_type  cur_x       = '0;
   coord_type  cur_y       = '0;
   coord_type  lo_x        = 10'd20;
   coord_type  hi_x        = 10'd526;
   coord_type  lo_y        = 10'd5;
   coord_type  hi_y        = 10'd791;
   logic [7:0] tap_div_cfg   = 8'd20;
   logic [7:0] swipe_div_cfg = 8'd6;
   logic [6:0] home_pct_cfg  = 7'd85;

   stroke_result_type pending_gestures[$];
   int unsigned    mismatch_count = 0;
   int unsigned    stall_cycles   = 0;
   int unsigned    phase_items    = 0;
   bit             idle_on        = 1'b1;
   bit             rsp_hold_req   = 1'b0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd100,  10'd100,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd1023, 10'd1023, 1'b1, 1'b1, '{GEST_TAP,   10'd100,  10'd100}},
      '{OP_DOWN, 10'd100,  10'd400,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd400,  10'd400,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_RIGHT, 10'd400,  10'd400}},
      '{OP_DOWN, 10'd400,  10'd400,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd100,  10'd400,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_LEFT,  10'd100,  10'd400}},
      '{OP_DOWN, 10'd300,  10'd100,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd300,  10'd500,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_DOWN,  10'd300,  10'd500}},
      '{OP_DOWN, 10'd300,  10'd500,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd300,  10'd100,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_UP,    10'd300,  10'd100}},
      '{OP_DOWN, 10'd300,  10'd750,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd300,  10'd400,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_HOME,  10'd300,  10'd400}},
      '{OP_DOWN, 10'd300,  10'd300,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd300,  10'd380,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_AMBIG, 10'd300,  10'd380}},
      '{OP_DOWN, 10'd0,    10'd0,    1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd1023, 10'd1023, 1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd0,    10'd0,    1'b1, 1'b1, '{GEST_DOWN,  10'd1023, 10'd1023}},
      '{OP_DOWN, 10'd600,  10'd512,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_DOWN, 10'd520,  10'd515,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}},
      '{OP_UP,   10'd77,   10'd901,  1'b0, 1'b0, '{GEST_TAP,   10'd0,    10'd0}}
   };

   touch_gesture_classifier u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_gesture (rsp_gesture),
      .rsp_end_x   (rsp_end_x),
      .rsp_end_y   (rsp_end_y),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic gesture_type judge_stroke();
      int unsigned adx, ady, rx, ry, span, tdiv, sdiv, tap_thr, swp_thr, pct;
      adx  = (cur_x >= org_x) ? int'(cur_x - org_x) : int'(org_x - cur_x);
      ady  = (cur_y >= org_y) ? int'(cur_y - org_y) : int'(org_y - cur_y);
      rx   = (hi_x >= lo_x) ? int'(hi_x - lo_x) : 0;
      ry   = (hi_y >= lo_y) ? int'(hi_y - lo_y) : 0;
      span = (rx > ry) ? rx : ry;
      tdiv = (tap_div_cfg == 8'd0) ? 1 : int'(tap_div_cfg);
      sdiv = (swipe_div_cfg == 8'd0) ? 1 : int'(swipe_div_cfg);
      tap_thr = span / tdiv;
      swp_thr = span / sdiv;
      if (adx < tap_thr && ady < tap_thr) return GEST_TAP;
      if (adx < swp_thr && ady < swp_thr) return GEST_AMBIG;
      if (ry == 0) pct = 50;
      else if (org_y < lo_y) pct = 0;
      else pct = (int'(org_y - lo_y) * 100) / ry;
      if (pct > home_pct_cfg && cur_y < org_y && ady > swp_thr) return GEST_HOME;
      if (adx > ady) return (cur_x > org_x) ? GEST_RIGHT : GEST_LEFT;
      return (cur_y > org_y) ? GEST_DOWN : GEST_UP;
   endfunction

   function automatic bit step_stroke(input logic op, input coord_type x, input coord_type y,
                                      output stroke_result_type res);
      res = '0;
      if (op == OP_DOWN) begin
         if (!stroke_on) begin
            org_x = x;
            org_y = y;
         end
         cur_x = x;
         cur_y = y;
         stroke_on = 1'b1;
         if (x < lo_x) lo_x = x;
         if (x > hi_x) hi_x = x;
         if (y < lo_y) lo_y = y;
         if (y > hi_y) hi_y = y;
         return 1'b0;
      end
      if (!stroke_on) return 1'b0;
      stroke_on = 1'b0;
      res.gesture = judge_stroke();
      res.end_x   = cur_x;
      res.end_y   = cur_y;
      return 1'b1;
   endfunction

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > 1023) return 10'd1023;
      return coord_type'(v);
   endfunction

   // called at a falling edge, returns at a falling edge with req_valid still high
   task automatic send_touch(input logic op, input coord_type x, input coord_type y,
                             input int row);
      stroke_result_type res;
      bit made;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      made = step_stroke(op, x, y, res);
      if (row >= 0 && directed_rows[row].typed) begin
         made = directed_rows[row].yields;
         res  = directed_rows[row].want;
      end
      if (made) pending_gestures.push_back(res);
      @(negedge clock);
   endtask

   task automatic send_stroke();
      int unsigned kind, moves, scale;
      int px, py;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // lone up, which ends a stroke only if the last stroke was left open
         send_touch(OP_UP, coord_type'($urandom_range(0, 1023)),
                    coord_type'($urandom_range(0, 1023)), -1);
         return;
      end
      px = $urandom_range(0, 1023);
      py = (kind == 1) ? $urandom_range(870, 1023) : $urandom_range(0, 1023);
      send_touch(OP_DOWN, coord_type'(px), coord_type'(py), -1);
      phase_items++;
      case ($urandom_range(0, 3))
         0: scale = 8;
         1: scale = 60;
         2: scale = 200;
         default: scale = 600;
      endcase
      moves = $urandom_range(0, 4);
      repeat (moves) begin
         px = clamp_coord(px + int'($urandom_range(0, 2 * scale)) - int'(scale));
         py = clamp_coord(py + int'($urandom_range(0, 2 * scale)) - int'(scale));
         send_touch(OP_DOWN, coord_type'(px), coord_type'(py), -1);
         phase_items++;
      end
      if (kind == 1) begin
         // swipe up from the bottom
         px = clamp_coord(px + int'($urandom_range(0, 100)) - 50);
         py = clamp_coord(py - int'($urandom_range(200, 900)));
         send_touch(OP_DOWN, coord_type'(px), coord_type'(py), -1);
         phase_items++;
      end
      if (kind != 9) begin
         send_touch(OP_UP, coord_type'($urandom_range(0, 1023)),
                    coord_type'($urandom_range(0, 1023)), -1);
         phase_items++;
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_TAP_DIV:   tap_div_cfg   = data;
         CSR_SWIPE_DIV: swipe_div_cfg = data;
         CSR_HOME_PCT:  home_pct_cfg  = data[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, wait for every stroke to come back, then let the divider go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_gestures.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      stroke_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_gestures.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected item, expected none, actual gesture %0d end %0d,%0d",
                     $time, rsp_gesture, rsp_end_x, rsp_end_y);
         end else begin
            want = pending_gestures.pop_front();
            if (rsp_gesture !== want.gesture) begin
               mismatch_count++;
               $display("%0t: gesture expected %0d actual %0d",
                        $time, want.gesture, rsp_gesture);
            end
            if (rsp_end_x !== want.end_x) begin
               mismatch_count++;
               $display("%0t: end_x expected %0d actual %0d", $time, want.end_x, rsp_end_x);
            end
            if (rsp_end_y !== want.end_y) begin
               mismatch_count++;
               $display("%0t: end_y expected %0d actual %0d", $time, want.end_y, rsp_end_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_touch(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y, i);
      end
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         case (ph)
            1: begin
               write_reg(CSR_TAP_DIV, 8'd0);
               write_reg(CSR_SWIPE_DIV, 8'd0);
               write_reg(CSR_HOME_PCT, 8'd0);
            end
            2: begin
               write_reg(CSR_TAP_DIV, 8'd255);
               write_reg(CSR_SWIPE_DIV, 8'd255);
               write_reg(CSR_HOME_PCT, 8'hFF);
               rsp_hold_req = 1'b1;
            end
            3: begin
               write_reg(CSR_TAP_DIV, 8'd1);
               write_reg(CSR_SWIPE_DIV, 8'd1);
               write_reg(CSR_HOME_PCT, 8'd100);
            end
            4: begin
               write_reg(CSR_TAP_DIV, 8'd255);
               write_reg(CSR_SWIPE_DIV, 8'd1);
               write_reg(CSR_HOME_PCT, 8'd50);
            end
            5: begin
               write_reg(CSR_TAP_DIV, 8'($urandom_range(0, 255)));
               write_reg(CSR_SWIPE_DIV, 8'($urandom_range(0, 255)));
               write_reg(CSR_HOME_PCT, 8'($urandom_range(0, 100)));
            end
            6: begin
               write_reg(CSR_SPARE, 8'($urandom_range(0, 255)));
               write_reg(CSR_TAP_DIV, 8'd20);
               write_reg(CSR_SWIPE_DIV, 8'd6);
               write_reg(CSR_HOME_PCT, 8'h55);
               idle_on = 1'b0;
            end
            default: ;
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_stroke();
      end
      settle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/tgc_pkg.sv
hw/rtl/tgc_front.sv
hw/rtl/tgc_queue.sv
hw/rtl/tgc_back.sv
hw/rtl/touch_gesture_classifier.sv
tb/tb_touch_gesture_classifier.sv
